@@ sv/gaiu_pkg.sv @@
// ----------------------------------------------------------------------------
// Gate array I/O package
// Item types, command codes and the RAM banking table that the gate array I/O
// and interrupt unit uses.
// ----------------------------------------------------------------------------
package gaiu_pkg;

	localparam int unsigned PEN_COUNT_DEF = 17;

	localparam logic [5:0] HSYNC_DIVISOR_RESET = 6'd52;

	localparam logic [1:0] KIND_IO    = 2'd0;
	localparam logic [1:0] KIND_ACK   = 2'd1;
	localparam logic [1:0] KIND_HSYNC = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	localparam logic [1:0] CMD_PEN  = 2'd0;
	localparam logic [1:0] CMD_INK  = 2'd1;
	localparam logic [1:0] CMD_MODE = 2'd2;
	localparam logic [1:0] CMD_BANK = 2'd3;

	localparam logic CFG_BANKING_ENABLED = 1'b0;
	localparam logic CFG_HSYNC_DIVISOR   = 1'b1;

	localparam logic [7:0] ACK_DATA = 8'hFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  data;
		logic        is_read;
	} req_t;

	typedef struct packed {
		logic        irq_pending;
		logic [1:0]  display_mode;
		logic        lower_rom_on;
		logic        upper_rom_on;
		logic [11:0] bank_map;
		logic        crtc_select;
		logic [1:0]  crtc_function;
		logic        ppi_select;
		logic [1:0]  ppi_register;
		logic [4:0]  ink_value;
		logic [7:0]  read_data;
	} rsp_t;

	// Physical bank of pages 3..0, three bits each, page 0 in the low bits.
	function automatic logic [11:0] bank_map_f(input logic [2:0] code);
		logic [11:0] map;
		unique case (code)
			3'd0: map = {3'd3, 3'd2, 3'd1, 3'd0};
			3'd1: map = {3'd7, 3'd2, 3'd1, 3'd0};
			3'd2: map = {3'd7, 3'd6, 3'd5, 3'd4};
			3'd3: map = {3'd7, 3'd2, 3'd3, 3'd0};
			3'd4: map = {3'd3, 3'd2, 3'd4, 3'd0};
			3'd5: map = {3'd3, 3'd2, 3'd5, 3'd0};
			3'd6: map = {3'd3, 3'd2, 3'd6, 3'd0};
			3'd7: map = {3'd3, 3'd2, 3'd7, 3'd0};
			default: map = {3'd3, 3'd2, 3'd1, 3'd0};
		endcase
		return map;
	endfunction

endpackage

@@ sv/gaiu_ink_file.sv @@
// ----------------------------------------------------------------------------
// Gate array ink file
// One ink register per pen, written at the selected pen and read at the
// queried pen. Pens at or above the pen count are not stored and read as zero.
// ----------------------------------------------------------------------------
module gaiu_ink_file #(
	parameter int unsigned PEN_COUNT = 17
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [4:0] wr_pen,
	input  logic [4:0] wr_ink,
	input  logic [7:0] rd_pen,
	output logic [4:0] rd_ink
);

	localparam int unsigned IDX_W = (PEN_COUNT > 1) ? $clog2(PEN_COUNT) : 1;

	logic [4:0] ink_q [PEN_COUNT];
	logic       wr_hit;
	logic       rd_hit;

	assign wr_hit = wr_en && ({3'b000, wr_pen} < 8'(PEN_COUNT));
	assign rd_hit = rd_pen < 8'(PEN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PEN_COUNT; i++) begin
				ink_q[i] <= '0;
			end
		end else if (wr_hit) begin
			ink_q[wr_pen[IDX_W-1:0]] <= wr_ink;
		end
	end

	assign rd_ink = rd_hit ? ink_q[rd_pen[IDX_W-1:0]] : 5'd0;

endmodule

@@ sv/gate_array_io_and_interrupt_unit.sv @@
// ----------------------------------------------------------------------------
// Gate array I/O and interrupt unit
// Decodes I/O accesses into gate array commands and CRTC/PPI selects, counts
// HSYNCs into a raster interrupt and answers pen ink queries.
//
//   Channel   Signals                          Handshake
//   request   req_valid, req_stall, req        accepted on valid and !stall
//   response  rsp_valid, rsp_stall, rsp        accepted on valid and !stall
//   config    cfg_valid, cfg_ready, cfg_index, written on valid and ready
//             cfg_data
//
// One item per cycle while the response side does not stall. An item is
// registered on entry and its result is registered as it advances. The result
// register frees a slot whenever the response is taken, so a stall on the
// response side reaches the request side only when both registers are full.
// Reset returns control and valid state to power-up values; data is not reset.
// ----------------------------------------------------------------------------
module gate_array_io_and_interrupt_unit #(
	parameter int unsigned PEN_COUNT = gaiu_pkg::PEN_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gaiu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gaiu_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [5:0]    cfg_data
);

	import gaiu_pkg::*;

	logic       banking_enabled_q;
	logic [5:0] hsync_divisor_q;
	logic [4:0] selected_pen_q;
	logic [1:0] mode_bits_q;
	logic       lower_rom_q;
	logic       upper_rom_q;
	logic [5:0] banking_code_q;
	logic [5:0] hsync_count_q;
	logic       irq_q;

	req_t       req_s1;
	logic       valid_s1;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	logic       advance;
	logic       gate_write;
	logic [1:0] cmd;
	logic       ink_wr;
	logic [4:0] ink_rd;
	logic [6:0] hsync_next;

	logic [4:0] selected_pen_d;
	logic [1:0] mode_bits_d;
	logic       lower_rom_d;
	logic       upper_rom_d;
	logic [5:0] banking_code_d;
	logic [5:0] hsync_count_d;
	logic       irq_d;
	rsp_t       rsp_d;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign gate_write = (req_s1.kind == KIND_IO) && !req_s1.is_read && !req_s1.address[15];
	assign cmd        = req_s1.data[7:6];
	assign ink_wr     = advance && gate_write && (cmd == CMD_INK);
	assign hsync_next = {1'b0, hsync_count_q} + 7'd1;

	gaiu_ink_file #(
		.PEN_COUNT (PEN_COUNT)
	) u_ink_file (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (ink_wr),
		.wr_pen (selected_pen_q),
		.wr_ink (req_s1.data[4:0]),
		.rd_pen (req_s1.data),
		.rd_ink (ink_rd)
	);

	always_comb begin
		selected_pen_d = selected_pen_q;
		mode_bits_d    = mode_bits_q;
		lower_rom_d    = lower_rom_q;
		upper_rom_d    = upper_rom_q;
		banking_code_d = banking_code_q;
		hsync_count_d  = hsync_count_q;
		irq_d          = irq_q;
		rsp_d          = '0;

		unique case (req_s1.kind)
			KIND_IO: begin
				if (gate_write) begin
					unique case (cmd)
						CMD_PEN: begin
							selected_pen_d = req_s1.data[4:0];
						end
						CMD_INK: begin
						end
						CMD_MODE: begin
							mode_bits_d = req_s1.data[1:0];
							lower_rom_d = !req_s1.data[2];
							upper_rom_d = !req_s1.data[3];
							if (req_s1.data[4]) begin
								hsync_count_d = '0;
								irq_d         = 1'b0;
							end
						end
						CMD_BANK: begin
							if (banking_enabled_q) begin
								banking_code_d = req_s1.data[5:0];
							end
						end
						default: begin
						end
					endcase
				end
				if (!req_s1.address[14]) begin
					rsp_d.crtc_select   = 1'b1;
					rsp_d.crtc_function = req_s1.address[9:8];
				end
				if (!req_s1.address[11]) begin
					rsp_d.ppi_select   = 1'b1;
					rsp_d.ppi_register = req_s1.address[1:0];
				end
			end
			KIND_ACK: begin
				irq_d           = 1'b0;
				rsp_d.read_data = ACK_DATA;
			end
			KIND_HSYNC: begin
				if (hsync_next >= {1'b0, hsync_divisor_q}) begin
					hsync_count_d = '0;
					irq_d         = 1'b1;
				end else begin
					hsync_count_d = hsync_next[5:0];
				end
			end
			KIND_QUERY: begin
				rsp_d.ink_value = ink_rd;
			end
			default: begin
			end
		endcase

		rsp_d.irq_pending  = irq_d;
		rsp_d.display_mode = mode_bits_d;
		rsp_d.lower_rom_on = lower_rom_d;
		rsp_d.upper_rom_on = upper_rom_d;
		rsp_d.bank_map     = bank_map_f(banking_enabled_q ? banking_code_d[2:0] : 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banking_enabled_q <= 1'b1;
			hsync_divisor_q   <= HSYNC_DIVISOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BANKING_ENABLED: banking_enabled_q <= cfg_data[0];
				CFG_HSYNC_DIVISOR:   hsync_divisor_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selected_pen_q <= '0;
			mode_bits_q    <= '0;
			lower_rom_q    <= 1'b1;
			upper_rom_q    <= 1'b1;
			banking_code_q <= '0;
			hsync_count_q  <= '0;
			irq_q          <= 1'b0;
		end else if (advance) begin
			selected_pen_q <= selected_pen_d;
			mode_bits_q    <= mode_bits_d;
			lower_rom_q    <= lower_rom_d;
			upper_rom_q    <= upper_rom_d;
			banking_code_q <= banking_code_d;
			hsync_count_q  <= hsync_count_d;
			irq_q          <= irq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

@@ tb/gate_array_io_and_interrupt_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Gate array I/O and interrupt unit testbench
// Drives I/O accesses, interrupt acknowledges, HSYNC ticks and pen queries
// through the request channel and checks every response field against a
// predictor of the gate array state. A short scripted sequence is followed by
// random phases under several register settings and flow-control mixes.
// ----------------------------------------------------------------------------
module gate_array_io_and_interrupt_unit_tb;

	import gaiu_pkg::*;

	localparam int PEN_COUNT = PEN_COUNT_DEF;
	localparam int SCRIPT_LEN = 25;
	localparam int PHASES = 6;
	localparam int STALL_LIMIT = 3000;

	localparam rsp_t NO_WANT = '0;
	localparam rsp_t RESET_ACK = {1'b0, 2'd0, 1'b1, 1'b1, 12'h688, 1'b0, 2'd0, 1'b0, 2'd0,
		5'd0, ACK_DATA};
	localparam rsp_t RESET_BOTH_SEL = {1'b0, 2'd0, 1'b1, 1'b1, 12'h688, 1'b1, 2'd0, 1'b1,
		2'd0, 5'd0, 8'h00};
	localparam rsp_t RESET_NO_SEL = {1'b0, 2'd0, 1'b1, 1'b1, 12'h688, 1'b0, 2'd0, 1'b0,
		2'd0, 5'd0, 8'h00};

	typedef struct packed {
		req_t item;
		logic typed;
		rsp_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_BANKING_ENABLED;
	logic [5:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	rsp_t expected_q[$];
	script_row_t script [SCRIPT_LEN];

	int phase_banking [PHASES] = '{1, 0, 1, 0, 1, 1};
	int phase_divisor [PHASES] = '{63, 1, 0, 52, 3, 52};
	int phase_flow [PHASES] = '{0, 0, 1, 1, 2, 2};
	int phase_items [PHASES] = '{200, 190, 190, 190, 190, 190};

	// Predicted gate array state.
	logic banking_on;
	logic [5:0] divisor;
	logic [4:0] pen_sel;
	logic [4:0] inks [PEN_COUNT];
	logic [1:0] mode;
	logic lower_rom;
	logic upper_rom;
	logic [5:0] bank_code;
	logic [5:0] line_count;
	logic irq;

	gate_array_io_and_interrupt_unit #(
		.PEN_COUNT(PEN_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [11:0] page_banks(input logic [2:0] code);
		logic [2:0] p0, p1, p2, p3;
		p0 = 3'd0;
		p1 = 3'd1;
		p2 = 3'd2;
		p3 = 3'd3;
		case (code)
			3'd1: p3 = 3'd7;
			3'd2: begin
				p0 = 3'd4;
				p1 = 3'd5;
				p2 = 3'd6;
				p3 = 3'd7;
			end
			3'd3: begin
				p1 = 3'd3;
				p3 = 3'd7;
			end
			3'd4: p1 = 3'd4;
			3'd5: p1 = 3'd5;
			3'd6: p1 = 3'd6;
			3'd7: p1 = 3'd7;
			default: p1 = 3'd1;
		endcase
		return {p3, p2, p1, p0};
	endfunction

	function automatic rsp_t gate_array_step(input req_t it);
		rsp_t r;
		logic [6:0] next_count;
		r = '0;
		case (it.kind)
			KIND_IO: begin
				if (!it.is_read && !it.address[15]) begin
					case (it.data[7:6])
						CMD_PEN: pen_sel = it.data[4:0];
						CMD_INK: if (pen_sel < PEN_COUNT) inks[pen_sel] = it.data[4:0];
						CMD_MODE: begin
							mode = it.data[1:0];
							lower_rom = !it.data[2];
							upper_rom = !it.data[3];
							if (it.data[4]) begin
								line_count = '0;
								irq = 1'b0;
							end
						end
						default: if (banking_on) bank_code = it.data[5:0];
					endcase
				end
				if (!it.address[14]) begin
					r.crtc_select = 1'b1;
					r.crtc_function = it.address[9:8];
				end
				if (!it.address[11]) begin
					r.ppi_select = 1'b1;
					r.ppi_register = it.address[1:0];
				end
			end
			KIND_ACK: begin
				irq = 1'b0;
				r.read_data = ACK_DATA;
			end
			KIND_HSYNC: begin
				next_count = {1'b0, line_count} + 7'd1;
				if (next_count >= {1'b0, divisor}) begin
					line_count = '0;
					irq = 1'b1;
				end else begin
					line_count = next_count[5:0];
				end
			end
			default: if (it.data < PEN_COUNT) r.ink_value = inks[it.data];
		endcase
		r.irq_pending = irq;
		r.display_mode = mode;
		r.lower_rom_on = lower_rom;
		r.upper_rom_on = upper_rom;
		r.bank_map = page_banks(banking_on ? bank_code[2:0] : 3'd0);
		return r;
	endfunction

	function automatic req_t random_item();
		req_t it;
		int unsigned pick;
		it.kind = KIND_IO;
		it.address = 16'($urandom);
		it.data = 8'($urandom);
		it.is_read = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if ($urandom_range(0, 9) < 7) begin
				it.address[15] = 1'b0;
				it.is_read = 1'b0;
			end
		end else if (pick < 55) begin
			it.kind = KIND_ACK;
		end else if (pick < 80) begin
			it.kind = KIND_HSYNC;
		end else begin
			it.kind = KIND_QUERY;
			if ($urandom_range(0, 3) != 0)
				it.data = 8'($urandom_range(0, PEN_COUNT + 2));
		end
		return it;
	endfunction

	task automatic check_field(input string name, input logic [11:0] want,
		input logic [11:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result(input rsp_t want, input rsp_t got);
		check_field("irq_pending", want.irq_pending, got.irq_pending);
		check_field("display_mode", want.display_mode, got.display_mode);
		check_field("lower_rom_on", want.lower_rom_on, got.lower_rom_on);
		check_field("upper_rom_on", want.upper_rom_on, got.upper_rom_on);
		check_field("bank_map", want.bank_map, got.bank_map);
		check_field("crtc_select", want.crtc_select, got.crtc_select);
		check_field("crtc_function", want.crtc_function, got.crtc_function);
		check_field("ppi_select", want.ppi_select, got.ppi_select);
		check_field("ppi_register", want.ppi_register, got.ppi_register);
		check_field("ink_value", want.ink_value, got.ink_value);
		check_field("read_data", want.read_data, got.read_data);
	endtask

	task automatic send_item(input req_t item, input logic typed, input rsp_t want);
		rsp_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall !== 1'b0);
		predicted = gate_array_step(item);
		expected_q.push_back(typed ? want : predicted);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [5:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (index == CFG_BANKING_ENABLED)
			banking_on = value[0];
		else
			divisor = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_flow(input int mix);
		case (mix)
			0: begin
				send_idle_pct = 31;
				recv_stall_pct = 72;
			end
			1: begin
				send_idle_pct = 72;
				recv_stall_pct = 31;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: expected none actual %h",
					$time, rsp);
				fail_count++;
			end else begin
				check_result(expected_q.pop_front(), rsp);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
				|| (cfg_valid && cfg_ready === 1'b1))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		script[0] = {KIND_ACK, 16'h0000, 8'h00, 1'b0, 1'b1, RESET_ACK};
		script[1] = {KIND_IO, 16'h0000, 8'h00, 1'b1, 1'b1, RESET_BOTH_SEL};
		script[2] = {KIND_IO, 16'hFFFF, 8'hFF, 1'b0, 1'b1, RESET_NO_SEL};
		script[3] = {KIND_IO, 16'h7F00, 8'h9C, 1'b1, 1'b0, NO_WANT};
		script[4] = {KIND_IO, 16'h7F00, 8'h00, 1'b0, 1'b0, NO_WANT};
		script[5] = {KIND_IO, 16'h7F00, 8'h5F, 1'b0, 1'b0, NO_WANT};
		script[6] = {KIND_QUERY, 16'h0000, 8'h00, 1'b0, 1'b0, NO_WANT};
		script[7] = {KIND_IO, 16'h7F00, 8'h10, 1'b0, 1'b0, NO_WANT};
		script[8] = {KIND_IO, 16'h7F00, 8'h55, 1'b0, 1'b0, NO_WANT};
		script[9] = {KIND_QUERY, 16'hFFFF, 8'h10, 1'b1, 1'b0, NO_WANT};
		script[10] = {KIND_IO, 16'h7F00, 8'h1F, 1'b0, 1'b0, NO_WANT};
		script[11] = {KIND_IO, 16'h7F00, 8'h4A, 1'b0, 1'b0, NO_WANT};
		script[12] = {KIND_QUERY, 16'h0000, 8'h1F, 1'b0, 1'b0, NO_WANT};
		script[13] = {KIND_QUERY, 16'h0000, 8'hFF, 1'b0, 1'b0, NO_WANT};
		script[14] = {KIND_IO, 16'h7F00, 8'h9F, 1'b0, 1'b0, NO_WANT};
		script[15] = {KIND_IO, 16'h7F00, 8'hC7, 1'b0, 1'b0, NO_WANT};
		script[16] = {KIND_IO, 16'h7F00, 8'hFF, 1'b0, 1'b0, NO_WANT};
		script[17] = {KIND_IO, 16'h7F00, 8'hC2, 1'b0, 1'b0, NO_WANT};
		script[18] = {KIND_IO, 16'hBD00, 8'h80, 1'b0, 1'b0, NO_WANT};
		script[19] = {KIND_IO, 16'hBE00, 8'h00, 1'b1, 1'b0, NO_WANT};
		script[20] = {KIND_IO, 16'hBF00, 8'h00, 1'b1, 1'b0, NO_WANT};
		script[21] = {KIND_IO, 16'hF403, 8'h00, 1'b0, 1'b0, NO_WANT};
		script[22] = {KIND_HSYNC, 16'hABCD, 8'h3C, 1'b1, 1'b0, NO_WANT};
		script[23] = {KIND_ACK, 16'h5555, 8'hAA, 1'b1, 1'b0, NO_WANT};
		script[24] = {KIND_IO, 16'h7F00, 8'h80, 1'b0, 1'b0, NO_WANT};

		banking_on = 1'b1;
		divisor = HSYNC_DIVISOR_RESET;
		pen_sel = '0;
		for (int i = 0; i < PEN_COUNT; i++)
			inks[i] = '0;
		mode = '0;
		lower_rom = 1'b1;
		upper_rom = 1'b1;
		bank_code = '0;
		line_count = '0;
		irq = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_flow(2);
		for (int i = 0; i < SCRIPT_LEN; i++)
			send_item(script[i].item, script[i].typed, script[i].want);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_reg(CFG_BANKING_ENABLED, 6'(phase_banking[p]));
			write_reg(CFG_HSYNC_DIVISOR, 6'(phase_divisor[p]));
			set_flow(phase_flow[p]);
			for (int i = 0; i < phase_items[p]; i++)
				send_item(random_item(), 1'b0, NO_WANT);
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
